// ===== hw/rtl/ffba_pkg.sv =====
package ffba_pkg;

	// Pool geometry
	localparam int POOL_WORDS = 1024;
	localparam int ADDR_W     = $clog2(POOL_WORDS);
	localparam int SIZE_W     = 11;
	localparam int HDR_W      = SIZE_W + 1;
	localparam int SUM_W      = SIZE_W + 1;

	// Configuration register
	localparam int SEG_W      = 11;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;
	localparam logic [0:0] REG_SEGMENT_WORDS = 1'b0;
	localparam logic [SEG_W-1:0] SEG_RESET = SEG_W'(POOL_WORDS);
	localparam logic [SEG_W-1:0] SEG_MIN   = SEG_W'(2);
	localparam logic [SEG_W-1:0] SEG_MAX   = SEG_W'(POOL_WORDS);

	// Header word: bit 11 set means allocated, low bits hold payload size
	localparam int ALLOC_BIT = SIZE_W;

	typedef enum logic [1:0] {
		MODE_FORMAT = 2'd0,
		MODE_ALLOC  = 2'd1,
		MODE_FREE   = 2'd2,
		MODE_QUERY  = 2'd3
	} mode_t;

	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_NO_ROOM = 1'b1;

	typedef struct packed {
		logic [1:0] mode;
		logic [9:0] request_words;
		logic [9:0] block_offset;
	} cmd_t;

	typedef struct packed {
		logic       status;
		logic [9:0] start_offset;
		logic [9:0] largest_words;
	} rsp_t;

endpackage

// ===== hw/rtl/ffba_ram.sv =====
module ffba_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/first_fit_block_allocator.sv =====
// Format runs ST_FMT; other items read and check each header, and a walk ends on reading the
// end marker. Outside free, a free block adds ST_MRD and ST_MEND, each merged neighbor
// ST_MCHK and ST_MRD, a run ended by an allocated header ST_MCHK, an allocate that fits
// ST_SPLIT, ST_FIN; done pulses in the cycle after. One item at a time, the next taken in
// the done cycle; busy covers the walk, set by the single header read port and shared adder.
// Results cannot be held off. Reset: async, active low; ST_INIT writes header 0 (busy high).
module first_fit_block_allocator
	import ffba_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// command channel
	input  logic               start,
	output logic               busy,
	input  cmd_t               cmd,
	// result channel
	output logic               done,
	output rsp_t               rsp,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_INIT  = 10'b0000000010,
		ST_FMT   = 10'b0000000100,
		ST_RD    = 10'b0000001000,
		ST_CHK   = 10'b0000010000,
		ST_MRD   = 10'b0000100000,
		ST_MCHK  = 10'b0001000000,
		ST_MEND  = 10'b0010000000,
		ST_SPLIT = 10'b0100000000,
		ST_FIN   = 10'b1000000000
	} state_t;

	state_t            state_q;
	mode_t             mode_q;
	logic [SEG_W-1:0]  seg_q;
	logic [ADDR_W-1:0] end_q;
	logic [SIZE_W-1:0] p_q;
	logic [SIZE_W-1:0] q_q;
	logic [SIZE_W-1:0] s_q;
	logic [SIZE_W-1:0] best_q;
	logic [SIZE_W-1:0] req_q;
	logic [SIZE_W-1:0] tgt_q;
	logic [SIZE_W-1:0] rem_q;
	logic              done_q;
	rsp_t              rsp_q;

	logic              cfg_wr;
	logic [SEG_W-1:0]  seg_clamp;
	logic [SIZE_W-1:0] end_ext;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [HDR_W-1:0]  mem_wdata;
	logic [ADDR_W-1:0] mem_raddr;
	logic [HDR_W-1:0]  mem_rdata;
	logic              hdr_alloc;
	logic [SIZE_W-1:0] hdr_size;

	logic [SIZE_W-1:0] add_a;
	logic [SIZE_W-1:0] add_b;
	logic              add_cin;
	logic [SUM_W-1:0]  sum;
	logic              carry;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_SEGMENT_WORDS);
	assign prdata = PDATA_W'(seg_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= SEG_RESET;
		end else if (cfg_wr) begin
			seg_q <= pwdata[SEG_W-1:0];
		end
	end

	// Pool length clamped to the supported range
	always_comb begin
		priority if (seg_q < SEG_MIN) begin
			seg_clamp = SEG_MIN;
		end else if (seg_q > SEG_MAX) begin
			seg_clamp = SEG_MAX;
		end else begin
			seg_clamp = seg_q;
		end
	end

	assign end_ext   = SIZE_W'(end_q);
	assign hdr_alloc = mem_rdata[ALLOC_BIT];
	assign hdr_size  = mem_rdata[SIZE_W-1:0];

	// Header memory
	ffba_ram #(
		.WIDTH(HDR_W),
		.DEPTH(POOL_WORDS)
	) u_hdr_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Shared adder: operands picked by the sequencer state
	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_cin = 1'b0;
		unique case (state_q)
			ST_RD: begin
				add_a = best_q;
				add_b = '1;
			end
			ST_CHK: begin
				add_a   = p_q;
				add_b   = hdr_size;
				add_cin = 1'b1;
			end
			ST_MRD: begin
				add_a   = p_q;
				add_b   = s_q;
				add_cin = 1'b1;
			end
			ST_MCHK: begin
				add_a   = s_q;
				add_b   = hdr_size;
				add_cin = 1'b1;
			end
			ST_MEND: begin
				add_a = s_q;
				add_b = (mode_q == MODE_ALLOC) ? ~req_q : ~best_q;
			end
			ST_SPLIT: begin
				add_a   = p_q;
				add_b   = req_q;
				add_cin = 1'b1;
			end
			ST_FIN: begin
				add_a   = p_q;
				add_cin = 1'b1;
			end
			default: begin
				add_a   = '0;
			end
		endcase
	end

	assign sum   = {1'b0, add_a} + {1'b0, add_b} + SUM_W'(add_cin);
	assign carry = sum[SUM_W-1];

	// Memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_raddr = p_q[ADDR_W-1:0];
		unique case (state_q)
			ST_INIT: begin
				mem_we    = 1'b1;
				mem_wdata = HDR_W'(POOL_WORDS - 2);
			end
			ST_FMT: begin
				mem_we    = 1'b1;
				mem_wdata = HDR_W'(seg_clamp - SEG_MIN);
			end
			ST_CHK: begin
				// free of an allocated header on the chain
				mem_we    = (mode_q == MODE_FREE) && (p_q == tgt_q) && hdr_alloc;
				mem_waddr = p_q[ADDR_W-1:0];
				mem_wdata = {1'b0, hdr_size};
			end
			ST_MRD: begin
				mem_raddr = sum[ADDR_W-1:0];
			end
			ST_MEND: begin
				mem_we    = 1'b1;
				mem_waddr = p_q[ADDR_W-1:0];
				mem_wdata = ((mode_q == MODE_ALLOC) && carry) ? {1'b1, req_q} : {1'b0, s_q};
			end
			ST_SPLIT: begin
				mem_we    = 1'b1;
				mem_waddr = sum[ADDR_W-1:0];
				mem_wdata = {1'b0, rem_q};
			end
			default: begin
				mem_raddr = p_q[ADDR_W-1:0];
			end
		endcase
	end

	// Result strobe: raised for the cycle after the sequencer's last step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_FMT) || (state_q == ST_FIN)
				|| ((state_q == ST_RD) && (p_q >= end_ext))
				|| ((state_q == ST_CHK) && (mode_q == MODE_FREE) && (p_q >= tgt_q));
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			end_q   <= ADDR_W'(POOL_WORDS - 1);
		end else begin
			unique case (state_q)
				ST_INIT: begin
					state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (start) begin
						mode_q <= mode_t'(cmd.mode);
						req_q  <= SIZE_W'(cmd.request_words);
						// offset zero wraps to a target no header reaches
						tgt_q  <= SIZE_W'(cmd.block_offset) - SIZE_W'(1);
						p_q    <= '0;
						best_q <= '0;
						state_q <= (mode_t'(cmd.mode) == MODE_FORMAT) ? ST_FMT : ST_RD;
					end
				end
				ST_FMT: begin
					end_q   <= ADDR_W'(seg_clamp - SEG_W'(1));
					rsp_q   <= '0;
					state_q <= ST_IDLE;
				end
				ST_RD: begin
					if (p_q >= end_ext) begin
						// walk reached the end marker
						rsp_q <= {((mode_q == MODE_ALLOC) ? STATUS_NO_ROOM : STATUS_OK), 10'd0,
							((mode_q == MODE_QUERY) && carry) ? sum[9:0] : 10'd0};
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (mode_q == MODE_FREE) begin
						if (p_q >= tgt_q) begin
							rsp_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							p_q     <= sum[SIZE_W-1:0];
							state_q <= ST_RD;
						end
					end else if (hdr_alloc) begin
						p_q     <= sum[SIZE_W-1:0];
						state_q <= ST_RD;
					end else begin
						s_q     <= hdr_size;
						state_q <= ST_MRD;
					end
				end
				ST_MRD: begin
					q_q     <= sum[SIZE_W-1:0];
					state_q <= (sum < {1'b0, end_ext}) ? ST_MCHK : ST_MEND;
				end
				ST_MCHK: begin
					if (hdr_alloc) begin
						state_q <= ST_MEND;
					end else begin
						s_q     <= sum[SIZE_W-1:0];
						state_q <= ST_MRD;
					end
				end
				ST_MEND: begin
					if (mode_q == MODE_ALLOC) begin
						if (carry) begin
							rem_q   <= sum[SIZE_W-1:0];
							state_q <= ST_SPLIT;
						end else begin
							p_q     <= q_q;
							state_q <= ST_RD;
						end
					end else begin
						if (carry) begin
							best_q <= s_q;
						end
						p_q     <= q_q;
						state_q <= ST_RD;
					end
				end
				ST_SPLIT: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					rsp_q   <= {STATUS_OK, sum[9:0], 10'd0};
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef SYNTHESIS
	// result strobe only once the sequencer is back at rest
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (state_q == ST_IDLE))
		else $error("result strobe while sequencer active");

	// strobe never lasts more than one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// header writes stay in front of the end marker
	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (SIZE_W'(mem_waddr) < end_ext))
		else $error("header write at or past chain end");

	// a header is only inspected when it lies on the chain
	a_chk_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHK) |-> (p_q < end_ext))
		else $error("header check past chain end");
`endif

endmodule

// ===== bench/tb_first_fit_block_allocator.sv =====
`timescale 1ns / 1ps

module tb_first_fit_block_allocator;
	import ffba_pkg::*;

	localparam int unsigned ITEM_TARGET = 1850;
	localparam int unsigned CYCLE_LIMIT = 40_000_000;

	// DUT signals; inputs driven to known values from time zero
	logic               clk     = 1'b0;
	logic               arst_n  = 1'b0;
	logic               start   = 1'b0;
	logic               busy;
	cmd_t               cmd     = '0;
	logic               done;
	rsp_t               rsp;
	logic               psel    = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite  = 1'b0;
	logic [PADDR_W-1:0] paddr   = '0;
	logic [PDATA_W-1:0] pwdata  = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	first_fit_block_allocator dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.done    (done),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the pool: one header per word, chain end, format length
	logic [HDR_W-1:0] shadow_hdr [POOL_WORDS];
	int unsigned      chain_end;
	logic [SEG_W-1:0] seg_shadow;

	rsp_t        pending_rsp [$];
	int unsigned live_blocks [$];
	int unsigned mismatches = 0;
	int unsigned cycles     = 0;

	// Run statistics
	int unsigned effective_count = 0;
	int unsigned total_items     = 0;
	int unsigned n_alloc_ok      = 0;
	int unsigned n_alloc_fail    = 0;
	int unsigned n_freed         = 0;
	int unsigned n_query         = 0;
	int unsigned n_format        = 0;
	int unsigned n_phases        = 0;

	function automatic int unsigned clamp_seg(logic [SEG_W-1:0] v);
		if (v < SEG_MIN)
			return 32'(SEG_MIN);
		if (v > SEG_MAX)
			return 32'(SEG_MAX);
		return 32'(v);
	endfunction

	function automatic void format_shadow();
		int unsigned w;
		w = clamp_seg(seg_shadow);
		for (int i = 0; i < POOL_WORDS; i++)
			shadow_hdr[i] = '0;
		chain_end = w - 1;
		shadow_hdr[0] = {1'b0, SIZE_W'(w - 2)};
	endfunction

	// Fold the run of free blocks behind the free block at p into it
	function automatic int unsigned merge_free_run(int unsigned p);
		int unsigned s;
		int unsigned q;
		s = 32'(shadow_hdr[p][SIZE_W-1:0]);
		q = p + 1 + s;
		while (q < chain_end && !shadow_hdr[q][ALLOC_BIT]) begin
			s = s + shadow_hdr[q][SIZE_W-1:0] + 1;
			q = p + 1 + s;
		end
		shadow_hdr[p] = {1'b0, SIZE_W'(s)};
		return s;
	endfunction

	// Apply one item to the shadow pool; returns 0 for an ignored free
	function automatic bit pool_step(input cmd_t c, output rsp_t r);
		int unsigned p;
		int unsigned s;
		int unsigned req;
		int unsigned target;
		int unsigned best;
		bit          found;
		bit          effective;
		r = '0;
		effective = 1'b1;
		p = 0;
		case (mode_t'(c.mode))
			MODE_FORMAT: begin
				format_shadow();
			end
			MODE_ALLOC: begin
				req = 32'(c.request_words);
				found = 1'b0;
				r.status = STATUS_NO_ROOM;
				while (p < chain_end && !found) begin
					if (!shadow_hdr[p][ALLOC_BIT]) begin
						s = merge_free_run(p);
						// split needs room for the request plus one header
						if (s >= req + 1) begin
							shadow_hdr[p] = {1'b1, SIZE_W'(req)};
							shadow_hdr[p + 1 + req] = {1'b0, SIZE_W'(s - 1 - req)};
							r.status = STATUS_OK;
							r.start_offset = 10'(p + 1);
							found = 1'b1;
						end
					end
					if (!found)
						p = p + 1 + shadow_hdr[p][SIZE_W-1:0];
				end
			end
			MODE_FREE: begin
				effective = 1'b0;
				if (c.block_offset != 0) begin
					target = c.block_offset - 1;
					while (p < chain_end && p < target)
						p = p + 1 + shadow_hdr[p][SIZE_W-1:0];
					if (p == target && p < chain_end && shadow_hdr[p][ALLOC_BIT]) begin
						shadow_hdr[p][ALLOC_BIT] = 1'b0;
						effective = 1'b1;
					end
				end
			end
			default: begin
				best = 0;
				while (p < chain_end) begin
					if (!shadow_hdr[p][ALLOC_BIT]) begin
						s = merge_free_run(p);
						if (s > best)
							best = s;
					end
					p = p + 1 + shadow_hdr[p][SIZE_W-1:0];
				end
				r.largest_words = (best >= 1) ? 10'(best - 1) : 10'd0;
			end
		endcase
		return effective;
	endfunction

	// Present one item, wait for it to be taken, then predict it
	task automatic issue(input cmd_t c, input bit typed, input rsp_t typed_rsp);
		rsp_t r;
		bit   effective;
		start <= 1'b1;
		cmd   <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		effective = pool_step(c, r);
		pending_rsp.push_back(typed ? typed_rsp : r);
		total_items++;
		if (effective)
			effective_count++;
		case (mode_t'(c.mode))
			MODE_FORMAT: begin
				n_format++;
				live_blocks.delete();
			end
			MODE_ALLOC: begin
				if (r.status == STATUS_OK) begin
					n_alloc_ok++;
					live_blocks.push_back(32'(r.start_offset));
				end else begin
					n_alloc_fail++;
				end
			end
			MODE_FREE: begin
				if (effective) begin
					n_freed++;
					foreach (live_blocks[i])
						if (live_blocks[i] == c.block_offset) begin
							live_blocks.delete(i);
							break;
						end
				end
			end
			default: n_query++;
		endcase
	endtask

	task automatic idle_cycles(input int unsigned n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Hold off until every expected item has come back and the block is idle
	task automatic drain_block();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending_rsp.size() != 0 || busy);
	endtask

	task automatic write_segment(input logic [SEG_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(4 * REG_SEGMENT_WORDS);
		pwdata  <= PDATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		seg_shadow = v;
	endtask

	function automatic cmd_t make_cmd(mode_t m, int unsigned req, int unsigned off);
		cmd_t c;
		c.mode          = m;
		c.request_words = 10'(req);
		c.block_offset  = 10'(off);
		return c;
	endfunction

	function automatic rsp_t make_rsp(bit st, int unsigned so, int unsigned lw);
		rsp_t r;
		r.status        = st;
		r.start_offset  = 10'(so);
		r.largest_words = 10'(lw);
		return r;
	endfunction

	// Directed rows: typed expectations only where obvious
	typedef struct {
		cmd_t c;
		bit   typed;
		rsp_t r;
	} row_t;

	row_t script [$];

	function automatic void add_row(mode_t m, int unsigned req, int unsigned off, bit typed,
			bit st, int unsigned so, int unsigned lw);
		row_t row;
		row.c     = make_cmd(m, req, off);
		row.typed = typed;
		row.r     = make_rsp(st, so, lw);
		script.push_back(row);
	endfunction

	// Result checker: field by field against the oldest expectation
	always @(posedge clk) begin
		rsp_t want;
		if (done) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected result status %0d start %0d largest %0d",
					$time, rsp.status, rsp.start_offset, rsp.largest_words);
				mismatches++;
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, rsp.status);
					mismatches++;
				end
				if (rsp.start_offset !== want.start_offset) begin
					$display("%0t: start_offset expected %0d actual %0d",
						$time, want.start_offset, rsp.start_offset);
					mismatches++;
				end
				if (rsp.largest_words !== want.largest_words) begin
					$display("%0t: largest_words expected %0d actual %0d",
						$time, want.largest_words, rsp.largest_words);
					mismatches++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d items outstanding", $time, pending_rsp.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		logic [SEG_W-1:0] seg_plan [7];
		logic [SEG_W-1:0] seg;
		int unsigned      words;
		int unsigned      n;
		int unsigned      req;
		int unsigned      off;
		int unsigned      pick;
		bit               quiet;
		mode_t            m;

		seg_plan = '{11'd2, 11'd0, 11'd2047, 11'd1, 11'd3, 11'd1025, 11'd1024};
		seg_shadow = SEG_RESET;
		format_shadow();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: full pool after reset, extremes, exact fit, ignored frees
		add_row(MODE_QUERY,     0,    0, 1, STATUS_OK,      0, 1021);
		add_row(MODE_ALLOC,     0,    0, 1, STATUS_OK,      1, 0);
		add_row(MODE_ALLOC,  1023,    0, 1, STATUS_NO_ROOM, 0, 0);
		add_row(MODE_FREE,      0,    0, 1, STATUS_OK,      0, 0);
		add_row(MODE_FREE,      0,    1, 1, STATUS_OK,      0, 0);
		add_row(MODE_FREE,      0,    1, 1, STATUS_OK,      0, 0);
		add_row(MODE_FREE,      0, 1023, 1, STATUS_OK,      0, 0);
		add_row(MODE_QUERY,     0,    0, 0, STATUS_OK,      0, 0);
		add_row(MODE_ALLOC,  1020,    0, 0, STATUS_OK,      0, 0);
		add_row(MODE_ALLOC,     0,    0, 0, STATUS_OK,      0, 0);
		add_row(MODE_ALLOC,     0,    0, 0, STATUS_OK,      0, 0);
		add_row(MODE_QUERY,     0,    0, 0, STATUS_OK,      0, 0);
		add_row(MODE_FREE,      0,  500, 1, STATUS_OK,      0, 0);
		add_row(MODE_FREE,      0,    1, 0, STATUS_OK,      0, 0);
		add_row(MODE_ALLOC,     1,    0, 0, STATUS_OK,      0, 0);
		add_row(MODE_FORMAT,    0,    0, 1, STATUS_OK,      0, 0);
		add_row(MODE_ALLOC,  1022,    0, 1, STATUS_NO_ROOM, 0, 0);
		add_row(MODE_ALLOC,  1021,    0, 1, STATUS_OK,      1, 0);
		add_row(MODE_QUERY,     0,    0, 0, STATUS_OK,      0, 0);
		add_row(MODE_FREE,      0,    1, 1, STATUS_OK,      0, 0);
		add_row(MODE_QUERY,     0,    0, 0, STATUS_OK,      0, 0);
		add_row(MODE_FORMAT,    0,    0, 1, STATUS_OK,      0, 0);
		foreach (script[i])
			issue(script[i].c, script[i].typed, script[i].r);

		// Random phases: new pool length, format, then mostly alloc/free traffic
		while (total_items < ITEM_TARGET) begin
			if (n_phases < 7)
				seg = seg_plan[n_phases];
			else if ($urandom_range(0, 99) < 15)
				seg = SEG_MAX;
			else
				seg = SEG_W'($urandom_range(4, 200));
			n_phases++;
			drain_block();
			write_segment(seg);
			words = clamp_seg(seg);
			issue(make_cmd(MODE_FORMAT, $urandom_range(0, 1023), $urandom_range(0, 1023)),
				1'b0, '0);

			n = $urandom_range(40, 140);
			quiet = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < n && total_items < ITEM_TARGET; k++) begin
				if (!quiet && total_items + 150 < ITEM_TARGET && $urandom_range(0, 3) == 0)
					idle_cycles($urandom_range(1, 17));
				if ($urandom_range(0, 60) == 0)
					drain_block();

				pick = $urandom_range(0, 99);
				req = $urandom_range(0, 1023);
				off = $urandom_range(0, 1023);
				if (pick < 45) begin
					m = MODE_ALLOC;
					pick = $urandom_range(0, 99);
					if (pick < 80)
						req = $urandom_range(0, (words / 6) + 1);
					else if (pick < 95)
						req = $urandom_range(0, words);
				end else if (pick < 80) begin
					m = MODE_FREE;
					// mostly live blocks; some stray offsets and double frees
					if (live_blocks.size() != 0 && $urandom_range(0, 99) < 85)
						off = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
				end else if (pick < 98) begin
					m = MODE_QUERY;
				end else begin
					m = MODE_FORMAT;
				end
				issue(make_cmd(m, req, off), 1'b0, '0);
			end
		end

		// Wind down: no idling left, wait for the tail of the results
		start <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("Covered %0d items over %0d pool lengths: %0d allocs granted, %0d refused,",
			total_items, n_phases, n_alloc_ok, n_alloc_fail);
		$display("%0d blocks freed, %0d largest-free queries, %0d formats, %0d mismatches",
			n_freed, n_query, n_format, mismatches);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
